// File: design/deq_pkg.sv
// shared types and constants for the double-ended queue
package deq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned WORD_W = 32;

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_BACK  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_BACK   = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t                     mode;
    logic signed [WORD_W-1:0]  push_value;
  } request_t;

  typedef struct packed {
    logic                      ok;
    logic signed [WORD_W-1:0]  popped_value;
    logic                      now_empty;
  } response_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic load_pop;
  } deq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pop_op;
  } deq_status_t;

endpackage

// File: design/double_ended_queue.sv
// top level of the bounded double-ended queue of signed words
// A bounded double-ended queue of signed 32-bit words held in a ring buffer of
// DEPTH entries. Each request beat carries a mode (push front, push back, pop
// front, pop back) and a word for pushes; each produces exactly one response
// beat with ok, the popped word (zero for pushes and refused pops) and whether
// the queue is empty afterwards. A push into a full queue or a pop from an
// empty one is refused and leaves the contents untouched. A push result goes
// straight to the output register; a pop first waits in a read state, as the
// entry ram has a registered read port and the popped word comes from it.
// The response sits in an output register, so a new request is taken in the
// same cycle the previous response is taken downstream. The entry ram is not
// cleared at reset, while the head index and fill count are.
module double_ended_queue #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               request_valid,
  output logic               request_stall,
  input  deq_pkg::request_t  request,
  output logic               response_valid,
  input  logic               response_stall,
  output deq_pkg::response_t response
);

  deq_pkg::deq_cmd_t    cmd;
  deq_pkg::deq_status_t status;

  // handshake sequencing
  deq_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .request_valid  (request_valid),
    .request_stall  (request_stall),
    .response_valid (response_valid),
    .response_stall (response_stall),
    .status         (status),
    .cmd            (cmd)
  );

  // ring pointers, entry storage and result register
  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .cmd      (cmd),
    .status   (status),
    .response (response)
  );

`ifndef NO_ASSERTIONS
  // a pop beat shows its result after the ram read and the read state
  a_pop_latency: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && status.pop_op |=> !response_valid ##1 response_valid)
    else $error("pop result not presented after ram read");

  // a push beat shows its result the next cycle
  a_push_latency: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && !status.pop_op |=> response_valid)
    else $error("push result not presented");

  // a new beat is never taken over a response still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> (!response_valid || !response_stall))
    else $error("request accepted while response held");

  // refused operations return a zero word
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    response_valid && !response.ok |-> response.popped_value == '0)
    else $error("refused operation returned a word");
`endif

endmodule

// File: design/deq_ram.sv
// generic simple dual-port ram with registered read
module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/deq_ctrl.sv
// controller for the double-ended queue: accept, ram read wait, result valid
module deq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 request_valid,
  output logic                 request_stall,
  output logic                 response_valid,
  input  logic                 response_stall,
  input  deq_pkg::deq_status_t status,
  output deq_pkg::deq_cmd_t    cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  state_t state;
  logic   take;
  logic   accept;

  assign take          = response_valid && !response_stall;
  assign request_stall = rst ||
                         !((state == ST_IDLE) && (!response_valid || !response_stall));
  assign accept        = request_valid && !request_stall;

  assign cmd.accept   = accept;
  assign cmd.load_pop = (state == ST_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      response_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && status.pop_op) begin
            // any held result has gone this cycle, the pop result follows the read
            state          <= ST_READ;
            response_valid <= 1'b0;
          end else if (accept) begin
            response_valid <= 1'b1;
          end else if (take) begin
            response_valid <= 1'b0;
          end
        end
        ST_READ: begin
          response_valid <= 1'b1;
          state          <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/deq_datapath.sv
// datapath: ring pointers, entry ram and result register
module deq_datapath #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT,
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  deq_pkg::request_t    request,
  input  deq_pkg::deq_cmd_t    cmd,
  output deq_pkg::deq_status_t status,
  output deq_pkg::response_t   response
);

  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW:0]   WRAP     = (CW + 1)'(DEPTH);

  logic [IW-1:0] head;
  logic [CW-1:0] count;
  logic          pend_ok;

  logic          is_pop;
  logic          full;
  logic          empty;
  logic [IW-1:0] head_dec;
  logic [IW-1:0] head_inc;
  logic [CW:0]   back_sum;
  logic [CW:0]   last_sum;
  logic [IW-1:0] back_idx;
  logic [IW-1:0] last_idx;
  logic          op_ok;

  logic                      wr_en;
  logic [IW-1:0]             wr_addr;
  logic                      rd_en;
  logic [IW-1:0]             rd_addr;
  logic [deq_pkg::WORD_W-1:0] rd_data;

  assign is_pop        = request.mode[1];
  assign status.pop_op = is_pop;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);

  assign head_dec = (head == '0) ? LAST_IDX : head - IW'(1);
  assign head_inc = (head == LAST_IDX) ? '0 : head + IW'(1);

  // ring offsets; back_sum stays below twice the depth, last_sum too unless empty
  assign back_sum = (CW + 1)'(head) + (CW + 1)'(count);
  assign last_sum = back_sum - (CW + 1)'(1);
  assign back_idx = (back_sum >= WRAP) ? IW'(back_sum - WRAP) : IW'(back_sum);
  assign last_idx = (last_sum >= WRAP) ? IW'(last_sum - WRAP) : IW'(last_sum);

  assign op_ok = is_pop ? !empty : !full;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = back_idx;
    rd_en   = 1'b0;
    rd_addr = head;
    case (request.mode)
      deq_pkg::MODE_PUSH_FRONT: begin
        wr_en   = cmd.accept && !full;
        wr_addr = head_dec;
      end
      deq_pkg::MODE_PUSH_BACK: begin
        wr_en   = cmd.accept && !full;
        wr_addr = back_idx;
      end
      deq_pkg::MODE_POP_FRONT: begin
        rd_en   = cmd.accept && !empty;
        rd_addr = head;
      end
      deq_pkg::MODE_POP_BACK: begin
        rd_en   = cmd.accept && !empty;
        rd_addr = last_idx;
      end
      default: begin
        wr_en = 1'b0;
        rd_en = 1'b0;
      end
    endcase
  end

  deq_ram #(
    .WIDTH (deq_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (request.push_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      count   <= '0;
      pend_ok <= 1'b0;
    end else if (cmd.accept) begin
      pend_ok <= is_pop && !empty;
      if (op_ok) begin
        case (request.mode)
          deq_pkg::MODE_PUSH_FRONT: begin
            head  <= head_dec;
            count <= count + CW'(1);
          end
          deq_pkg::MODE_PUSH_BACK: begin
            count <= count + CW'(1);
          end
          deq_pkg::MODE_POP_FRONT: begin
            head  <= head_inc;
            count <= count - CW'(1);
          end
          deq_pkg::MODE_POP_BACK: begin
            count <= count - CW'(1);
          end
          default: begin
            count <= count;
          end
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      response.ok           <= op_ok;
      response.popped_value <= '0;
      response.now_empty    <= is_pop && (count < CW'(2));
    end else if (cmd.load_pop && pend_ok) begin
      response.popped_value <= rd_data;
    end
  end

endmodule
